[design/radix2_complex_fft_top_assert.svh]
// Assertion macros used by the FFT controller.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef RADIX2_COMPLEX_FFT_TOP_ASSERT_SVH
`define RADIX2_COMPLEX_FFT_TOP_ASSERT_SVH

// Condition in the same cycle as the trigger.
`define R2F_ASSERT_NOW(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error(msg);

// Condition in the cycle after the trigger.
`define R2F_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error(msg);

`endif

[design/r2f_pkg.sv]
// Shared constants, types and functions of the radix-2 FFT.
// No dependencies; used by the controller, the datapath and the top level.
package r2f_pkg;

  localparam int POINTS = 512;
  localparam int AW     = 9;
  localparam int SW     = 32;
  localparam int TWW    = 18;
  localparam int TWN    = 256;
  localparam int TWA    = 8;

  localparam logic [1:0] FUNC_LOAD = 2'd0;
  localparam logic [1:0] FUNC_RUN  = 2'd1;
  localparam logic [1:0] FUNC_READ = 2'd2;

  localparam logic REG_INVERSE = 1'b0;
  localparam logic REG_SCALE   = 1'b1;

  typedef enum logic [2:0] {
    WSRC_LOAD, WSRC_COPY, WSRC_TOP, WSRC_BOT, WSRC_SCALE
  } wsrc_t;

  typedef struct packed {
    logic [AW-1:0]  rd_addr;
    logic           rd_dst;
    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    logic           wr_dst;
    wsrc_t          wsrc;
    logic [TWA-1:0] tw_idx;
    logic           ld_w;
    logic           cap_a;
    logic           mul_en;
    logic           add_en;
    logic           sum_en;
    logic           clr_flag;
    logic           swap;
    logic           out_rd;
    logic           out_run;
  } cmd_t;

  typedef struct packed {
    logic [SW-1:0] val;
    logic          hit;
  } sat_t;

  typedef logic signed [TWW-1:0] tw_arr_t [TWN];

  function automatic logic [AW-1:0] bitrev(input logic [AW-1:0] v);
    logic [AW-1:0] r;
    for (int b = 0; b < AW; b++) r[AW-1-b] = v[b];
    return r;
  endfunction

  // Rounds a Q28.24 product sum half up to Q24.8 and saturates it.
  function automatic sat_t round_sat(input logic signed [51:0] v);
    logic signed [51:0] t;
    logic signed [35:0] q;
    sat_t r;
    t = v + 52'sd32768;
    q = t[51:16];
    if (q > 36'sh07FFFFFFF) begin
      r.val = 32'h7FFFFFFF;
      r.hit = 1'b1;
    end else if (q < -36'sh080000000) begin
      r.val = 32'h80000000;
      r.hit = 1'b1;
    end else begin
      r.val = q[31:0];
      r.hit = 1'b0;
    end
    return r;
  endfunction

  // Shift-and-subtract division, used only while the constant twiddle table is built.
  function automatic longint unsigned div_u64(input longint unsigned num,
                                              input longint unsigned den);
    longint unsigned q, rem;
    q = 0;
    rem = 0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem = rem - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic longint to_q16(input longint v);
    longint c;
    c = v;
    if (c < 0) c = 0;
    if (c > 64'sd1073741824) c = 64'sd1073741824;
    return (c + 8192) >> 14;
  endfunction

  // Taylor series on the first quadrant, x in Q2.30; returns cos or sin in Q1.16.
  function automatic longint quad_trig(input longint unsigned x, input bit want_sin);
    longint unsigned x2, tc, ts, dc, ds;
    longint sc, ss;
    x2 = (x * x) >> 30;
    tc = 64'd1073741824;
    ts = x;
    sc = 64'sd1073741824;
    ss = longint'(x);
    for (int n = 1; n <= 12; n++) begin
      dc = longint'((2 * n - 1) * (2 * n));
      ds = longint'((2 * n) * (2 * n + 1));
      tc = div_u64((tc * x2) >> 30, dc);
      ts = div_u64((ts * x2) >> 30, ds);
      if ((n & 1) == 1) begin
        sc = sc - longint'(tc);
        ss = ss - longint'(ts);
      end else begin
        sc = sc + longint'(tc);
        ss = ss + longint'(ts);
      end
    end
    return want_sin ? to_q16(ss) : to_q16(sc);
  endfunction

  // The angle step divides by twice the point count, which is 2^(AW+1).
  function automatic tw_arr_t make_tw(input bit want_sin);
    tw_arr_t t;
    longint unsigned pi_q30;
    longint unsigned x;
    longint c, s;
    pi_q30 = 64'd3373259426;
    for (int k = 0; k < TWN; k++) begin
      if (4 * k < POINTS) begin
        x = (pi_q30 * longint'(4 * k)) >> (AW + 1);
        c = quad_trig(x, 1'b0);
        s = quad_trig(x, 1'b1);
      end else begin
        x = (pi_q30 * longint'(4 * k - POINTS)) >> (AW + 1);
        c = -quad_trig(x, 1'b1);
        s = quad_trig(x, 1'b0);
      end
      t[k] = want_sin ? TWW'(s) : TWW'(c);
    end
    return t;
  endfunction

endpackage

[design/r2f_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module r2f_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[design/r2f_datapath.sv]
// FFT datapath: both sample banks, twiddle table, butterfly arithmetic, output registers.
// Depends on r2f_pkg and r2f_ram; driven by r2f_ctrl through cmd_t.
module r2f_datapath import r2f_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cmd_t                 cmd,
  input  logic                 inverse,
  input  logic signed [SW-1:0] ld_real,
  input  logic signed [SW-1:0] ld_imag,
  output logic signed [SW-1:0] out_real,
  output logic signed [SW-1:0] out_imag,
  output logic                 out_done,
  output logic                 out_ovf
);

  localparam tw_arr_t TW_COS = make_tw(1'b0);
  localparam tw_arr_t TW_SIN = make_tw(1'b1);

  logic bank_r, rsel_r, flag_r;
  logic [2*SW-1:0] rd0, rd1, rdata, wdata;
  logic wbank;
  logic signed [TWW-1:0] wr_r, wi_r;
  logic signed [SW-1:0] a_re_r, a_im_r, b_re, b_im;
  logic signed [49:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r;
  logic signed [50:0] pr_r, pi_r;
  logic signed [51:0] ash_re, ash_im;
  sat_t top_re, top_im, bot_re, bot_im;
  logic [SW-1:0] top_re_r, top_im_r, bot_re_r, bot_im_r;
  logic signed [SW:0] sc_re, sc_im;
  logic [SW-1:0] out_real_r, out_imag_r;
  logic out_done_r, out_ovf_r;

  assign rdata = rsel_r ? rd1 : rd0;
  assign wbank = cmd.wr_dst ? ~bank_r : bank_r;
  assign b_re  = rdata[SW-1:0];
  assign b_im  = rdata[2*SW-1:SW];

  assign ash_re = {{4{a_re_r[SW-1]}}, a_re_r, 16'd0};
  assign ash_im = {{4{a_im_r[SW-1]}}, a_im_r, 16'd0};
  assign top_re = round_sat(ash_re + 52'(pr_r));
  assign top_im = round_sat(ash_im + 52'(pi_r));
  assign bot_re = round_sat(ash_re - 52'(pr_r));
  assign bot_im = round_sat(ash_im - 52'(pi_r));

  // Divide by the point count, rounding half up: floor((v + 256) / 512).
  assign sc_re = 33'(b_re) + 33'sd256;
  assign sc_im = 33'(b_im) + 33'sd256;

  always_comb begin
    unique case (cmd.wsrc)
      WSRC_LOAD:  wdata = {ld_imag, ld_real};
      WSRC_COPY:  wdata = rdata;
      WSRC_TOP:   wdata = {top_im_r, top_re_r};
      WSRC_BOT:   wdata = {bot_im_r, bot_re_r};
      WSRC_SCALE: wdata = {{8{sc_im[SW]}}, sc_im[SW:9], {8{sc_re[SW]}}, sc_re[SW:9]};
      default:    wdata = rdata;
    endcase
  end

  r2f_ram #(.WIDTH(2*SW), .DEPTH(POINTS)) u_bank0 (
    .clk(clk), .we(cmd.wr_en && !wbank), .waddr(cmd.wr_addr), .wdata(wdata),
    .raddr(cmd.rd_addr), .rdata(rd0)
  );

  r2f_ram #(.WIDTH(2*SW), .DEPTH(POINTS)) u_bank1 (
    .clk(clk), .we(cmd.wr_en && wbank), .waddr(cmd.wr_addr), .wdata(wdata),
    .raddr(cmd.rd_addr), .rdata(rd1)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r <= 1'b0;
      flag_r <= 1'b0;
      rsel_r <= 1'b0;
    end else begin
      rsel_r <= cmd.rd_dst ? ~bank_r : bank_r;
      if (cmd.swap) bank_r <= ~bank_r;
      if (cmd.clr_flag) begin
        flag_r <= 1'b0;
      end else if (cmd.sum_en) begin
        flag_r <= flag_r | top_re.hit | top_im.hit | bot_re.hit | bot_im.hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_w) begin
      wr_r <= TW_COS[cmd.tw_idx];
      wi_r <= inverse ? TW_SIN[cmd.tw_idx] : -TW_SIN[cmd.tw_idx];
    end
    if (cmd.cap_a) begin
      a_re_r <= b_re;
      a_im_r <= b_im;
    end
    if (cmd.mul_en) begin
      p_rr_r <= b_re * wr_r;
      p_ii_r <= b_im * wi_r;
      p_ri_r <= b_re * wi_r;
      p_ir_r <= b_im * wr_r;
    end
    if (cmd.add_en) begin
      pr_r <= 51'(p_rr_r) - 51'(p_ii_r);
      pi_r <= 51'(p_ri_r) + 51'(p_ir_r);
    end
    if (cmd.sum_en) begin
      top_re_r <= top_re.val;
      top_im_r <= top_im.val;
      bot_re_r <= bot_re.val;
      bot_im_r <= bot_im.val;
    end
    if (cmd.out_rd) begin
      out_real_r <= b_re;
      out_imag_r <= b_im;
      out_done_r <= 1'b0;
      out_ovf_r  <= flag_r;
    end else if (cmd.out_run) begin
      out_real_r <= '0;
      out_imag_r <= '0;
      out_done_r <= 1'b1;
      out_ovf_r  <= flag_r;
    end
  end

  assign out_real = out_real_r;
  assign out_imag = out_imag_r;
  assign out_done = out_done_r;
  assign out_ovf  = out_ovf_r;

endmodule

[design/r2f_ctrl.sv]
// FFT controller: command decode, bit-reverse copy, butterfly sequencing, scaling pass.
// Depends on r2f_pkg; drives r2f_datapath through cmd_t.
`include "radix2_complex_fft_top_assert.svh"
module r2f_ctrl import r2f_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [1:0]    func,
  input  logic [AW-1:0] index,
  input  logic          scale,
  output logic          busy,
  output logic          out_valid,
  output cmd_t          cmd
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD, ST_COPY, ST_RA, ST_RB, ST_MUL, ST_ADD, ST_SUM,
    ST_WA, ST_WB, ST_SC_RD, ST_SC_WR, ST_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic [AW:0]    cnt_r, cnt_nxt;
  logic [3:0]     stg_r, stg_nxt;
  logic [TWA-1:0] bfly_r, bfly_nxt;
  logic           out_valid_r;
  logic [AW-1:0]  kx, grp, jm, half, addr_a, addr_b, twf;
  logic           accept;

  assign accept = start && (state_r == ST_IDLE);

  // Butterfly addresses: a = group * 2 * half + j, b = a + half.
  assign kx     = {1'b0, bfly_r};
  assign half   = AW'(1) << stg_r;
  assign grp    = kx >> stg_r;
  assign jm     = kx & (half - AW'(1));
  assign addr_a = (grp << (stg_r + 4'd1)) | jm;
  assign addr_b = addr_a | half;
  assign twf    = jm << (4'd8 - stg_r);

  always_comb begin
    cmd       = '0;
    cmd.wsrc  = WSRC_LOAD;
    cmd.tw_idx = twf[TWA-1:0];
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    stg_nxt   = stg_r;
    bfly_nxt  = bfly_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          priority case (func)
            FUNC_LOAD: begin
              cmd.wr_en   = 1'b1;
              cmd.wr_addr = index;
            end
            FUNC_READ: begin
              cmd.rd_addr = index;
              state_nxt   = ST_RD;
            end
            FUNC_RUN: begin
              cmd.clr_flag = 1'b1;
              cnt_nxt      = '0;
              state_nxt    = ST_COPY;
            end
            default: ;
          endcase
        end
      end
      ST_RD: begin
        cmd.out_rd = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_COPY: begin
        // Read the source in order and write the previous entry bit-reversed.
        cmd.rd_addr = cnt_r[AW-1:0];
        if (cnt_r != '0) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_dst  = 1'b1;
          cmd.wr_addr = bitrev(cnt_r[AW-1:0] - AW'(1));
          cmd.wsrc    = WSRC_COPY;
        end
        if (cnt_r == (AW+1)'(POINTS)) begin
          stg_nxt   = '0;
          bfly_nxt  = '0;
          state_nxt = ST_RA;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_RA: begin
        cmd.rd_addr = addr_a;
        cmd.rd_dst  = 1'b1;
        cmd.ld_w    = 1'b1;
        state_nxt   = ST_RB;
      end
      ST_RB: begin
        cmd.rd_addr = addr_b;
        cmd.rd_dst  = 1'b1;
        cmd.cap_a   = 1'b1;
        state_nxt   = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = ST_ADD;
      end
      ST_ADD: begin
        cmd.add_en = 1'b1;
        state_nxt  = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum_en = 1'b1;
        state_nxt  = ST_WA;
      end
      ST_WA: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_dst  = 1'b1;
        cmd.wr_addr = addr_a;
        cmd.wsrc    = WSRC_TOP;
        state_nxt   = ST_WB;
      end
      ST_WB: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_dst  = 1'b1;
        cmd.wr_addr = addr_b;
        cmd.wsrc    = WSRC_BOT;
        bfly_nxt    = bfly_r + 1'b1;
        state_nxt   = ST_RA;
        if (bfly_r == TWA'(TWN - 1)) begin
          if (stg_r == 4'(AW - 1)) begin
            cnt_nxt   = '0;
            state_nxt = scale ? ST_SC_RD : ST_DONE;
          end else begin
            stg_nxt = stg_r + 1'b1;
          end
        end
      end
      ST_SC_RD: begin
        cmd.rd_addr = cnt_r[AW-1:0];
        cmd.rd_dst  = 1'b1;
        state_nxt   = ST_SC_WR;
      end
      ST_SC_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_dst  = 1'b1;
        cmd.wr_addr = cnt_r[AW-1:0];
        cmd.wsrc    = WSRC_SCALE;
        cnt_nxt     = cnt_r + 1'b1;
        state_nxt   = (cnt_r == (AW+1)'(POINTS - 1)) ? ST_DONE : ST_SC_RD;
      end
      ST_DONE: begin
        cmd.out_run = 1'b1;
        cmd.swap    = 1'b1;
        state_nxt   = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      stg_r       <= '0;
      bfly_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      stg_r       <= stg_nxt;
      bfly_r      <= bfly_nxt;
      out_valid_r <= (state_r == ST_RD) || (state_r == ST_DONE);
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  `R2F_ASSERT_NEXT(a_strobe_single, out_valid_r, !out_valid_r, "result strobe held two cycles")
  `R2F_ASSERT_NEXT(a_run_busy, accept && func == FUNC_RUN, busy, "run item did not start")
  `R2F_ASSERT_NOW(a_no_write_idle_dst, state_r == ST_IDLE, !cmd.wr_dst, "idle write to other bank")

endmodule

[design/radix2_complex_fft_top.sv]
// Top level of the radix-2 complex FFT: configuration registers and APB-style port.
// Depends on r2f_pkg, r2f_ctrl and r2f_datapath.
//
// An item is taken at a rising edge with start high and busy low. A load item
// (func 0) writes one Q24.8 complex sample into the active bank; busy stays
// low. A read item (func 2) keeps busy high for one cycle and its result
// appears on the out_ ports, marked by out_valid, in the cycle after that. A run
// item (func 1) copies the active bank bit-reversed into the other bank, walks
// 9 stages of 256 butterflies, each through the states RA, RB, MUL, ADD, SUM, WA
// and WB in turn, as each bank memory has a single read and write port, adds
// a divide-by-512 pass when scale_output is set, and then strobes a result with
// out_transform_done high. The run leaves the transformed bank active. out_valid
// is high for exactly one cycle per result and the receiver cannot stall it, so
// a result must be captured in that cycle. Configuration must be written only
// while busy is low and no result is pending; the user must keep to this, as
// the block itself does not enforce it.
module radix2_complex_fft_top import r2f_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           in_func,
  input  logic [AW-1:0]        in_sample_index,
  input  logic signed [SW-1:0] in_sample_real,
  input  logic signed [SW-1:0] in_sample_imag,
  output logic                 out_valid,
  output logic signed [SW-1:0] out_result_real,
  output logic signed [SW-1:0] out_result_imag,
  output logic                 out_transform_done,
  output logic                 out_overflow_seen,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  cmd_t cmd;
  logic inverse_r, scale_r;
  logic reg_sel;

  // Register index is the word address bit paddr[2]; the low two bits are ignored.
  assign reg_sel = paddr[2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inverse_r <= 1'b0;
      scale_r   <= 1'b0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_INVERSE: inverse_r <= pwdata[0];
        REG_SCALE:   scale_r   <= pwdata[0];
        default: ;
      endcase
    end
  end

  assign prdata = {31'd0, (reg_sel == REG_SCALE) ? scale_r : inverse_r};

  r2f_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .func(in_func),
    .index(in_sample_index), .scale(scale_r), .busy(busy),
    .out_valid(out_valid), .cmd(cmd)
  );

  r2f_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .inverse(inverse_r),
    .ld_real(in_sample_real), .ld_imag(in_sample_imag),
    .out_real(out_result_real), .out_imag(out_result_imag),
    .out_done(out_transform_done), .out_ovf(out_overflow_seen)
  );

endmodule
